>>> hdl/risr_pkg.sv
// Shared constants for the rounded integer square root block.
`default_nettype none

package risr_pkg;

   // Width of the rounded root on the result channel.
   localparam int unsigned ROOT_BITS = 16;

endpackage : risr_pkg

`default_nettype wire

>>> hdl/risr_cell.sv
// One digit step of the square root chain: brings down two radicand bits, decides one root bit.
`default_nettype none

module risr_cell #(
   parameter int unsigned RAD_W  = 32,
   parameter int unsigned ROOT_W = 16,
   parameter int unsigned REM_W  = 18
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // upstream side
   input  wire logic              in_valid,
   input  wire logic [RAD_W-1:0]  in_rad,
   input  wire logic [ROOT_W-1:0] in_root,
   input  wire logic [REM_W-1:0]  in_rem,
   output logic                   in_ready,
   // downstream side
   output logic                   out_valid,
   output logic [RAD_W-1:0]       out_rad,
   output logic [ROOT_W-1:0]      out_root,
   output logic [REM_W-1:0]       out_rem,
   input  wire logic              out_ready
);

   localparam int unsigned WIDE_W = REM_W + 2;

   logic              valid_ff;
   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [WIDE_W-1:0] rem_shift;
   logic [WIDE_W-1:0] trial;
   logic [WIDE_W-1:0] diff;
   logic              fit;

   // stage takes a beat when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;

   // trial subtract of (4*root + 1) from the remainder with two new bits
   always_comb begin
      rem_shift = {in_rem, in_rad[RAD_W-1 -: 2]};
      trial     = {{(WIDE_W - ROOT_W - 2){1'b0}}, in_root, 2'b01};
      fit       = (rem_shift >= trial);
      diff      = rem_shift - trial;
      rem_in    = fit ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
      root_in   = ROOT_W'({in_root, fit});
      rad_in    = RAD_W'({in_rad, 2'b00});
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_root  = root_ff;
   assign out_rem   = rem_ff;

endmodule : risr_cell

`default_nettype wire

>>> hdl/risr_round.sv
// Final stage: rounds the floor root to nearest and holds the result beat.
`default_nettype none

module risr_round
   import risr_pkg::*;
#(
   parameter int unsigned ROOT_W = 16,
   parameter int unsigned REM_W  = 18
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [ROOT_W-1:0]    in_root,
   input  wire logic [REM_W-1:0]     in_rem,
   output logic                      in_ready,
   output logic                      rsp_valid,
   output logic [ROOT_BITS-1:0]      rsp_root,
   input  wire logic                 rsp_stall
);

   localparam int unsigned SUM_W = ROOT_W + 1;
   localparam int unsigned EXT_W = (SUM_W > ROOT_BITS) ? SUM_W : ROOT_BITS;

   logic                 valid_ff;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic                 round_up;
   logic [SUM_W-1:0]     sum;
   logic [EXT_W-1:0]     sum_ext;

   assign in_ready = !valid_ff || !rsp_stall;

   // remainder above the floor root means x > r*r + r: round up
   always_comb begin
      round_up = (in_rem > REM_W'(in_root));
      sum      = {1'b0, in_root} + SUM_W'(round_up);
      sum_ext  = EXT_W'(sum);
      root_in  = sum_ext[ROOT_BITS-1:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         root_ff  <= '0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
         if (in_valid) begin
            root_ff <= root_in;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_root  = root_ff;

endmodule : risr_round

`default_nettype wire

>>> hdl/rounded_integer_square_root.sv
// Top level of the rounded integer square root: a chain of digit cells and a rounding stage.
//
// Usage:
//   Request channel (req_valid, req_stall, req_radicand) carries one unsigned radicand per
//   beat; response channel (rsp_valid, rsp_stall, rsp_root) returns round(sqrt(radicand)),
//   16 bits, in the same order. A beat moves when valid is high and stall is low.
//   Structure: one cell per root bit, most significant first, then the rounding stage.
//   Throughput: one beat per cycle while req_stall is low; each cell resolves one root bit and
//   hands its remainder, partial root and remaining radicand bits to the next cell.
//   Stall: each stage holds its beat only while the stage after it is full and stalled, so
//   empty stages keep filling while a finished result waits; req_stall rises only once the
//   whole chain is full behind a stalled response.
//   Reset: synchronous, active high; all stage valids clear and the result reads 0.
//   If RADICAND_BITS makes the rounded root exceed 16 bits, rsp_root keeps its low 16 bits.
`default_nettype none

module rounded_integer_square_root
   import risr_pkg::*;
#(
   parameter int unsigned RADICAND_BITS = 31
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [RADICAND_BITS-1:0] req_radicand,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [ROOT_BITS-1:0]          rsp_root
);

   localparam int unsigned STEPS  = (RADICAND_BITS + 1) / 2;
   localparam int unsigned RAD_W  = 2 * STEPS;
   localparam int unsigned ROOT_W = STEPS;
   localparam int unsigned REM_W  = STEPS + 2;

   // links between stages; link 0 is the request side
   logic              link_valid [STEPS+1];
   logic              link_ready [STEPS+1];
   logic [RAD_W-1:0]  link_rad   [STEPS+1];
   logic [ROOT_W-1:0] link_root  [STEPS+1];
   logic [REM_W-1:0]  link_rem   [STEPS+1];

   // request feeds the first cell with a zero root and remainder
   assign link_valid[0] = req_valid;
   assign link_rad[0]   = RAD_W'(req_radicand);
   assign link_root[0]  = '0;
   assign link_rem[0]   = '0;
   assign req_stall     = !link_ready[0];

   // one cell per root bit, most significant first
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      risr_cell #(
         .RAD_W  (RAD_W),
         .ROOT_W (ROOT_W),
         .REM_W  (REM_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_rad    (link_rad[i]),
         .in_root   (link_root[i]),
         .in_rem    (link_rem[i]),
         .in_ready  (link_ready[i]),
         .out_valid (link_valid[i+1]),
         .out_rad   (link_rad[i+1]),
         .out_root  (link_root[i+1]),
         .out_rem   (link_rem[i+1]),
         .out_ready (link_ready[i+1])
      );
   end

   // rounding and result register
   risr_round #(
      .ROOT_W (ROOT_W),
      .REM_W  (REM_W)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[STEPS]),
      .in_root   (link_root[STEPS]),
      .in_rem    (link_rem[STEPS]),
      .in_ready  (link_ready[STEPS]),
      .rsp_valid (rsp_valid),
      .rsp_root  (rsp_root),
      .rsp_stall (rsp_stall)
   );

endmodule : rounded_integer_square_root

`default_nettype wire

>>> hdl/risr_check.sv
// Port-level checker for the rounded integer square root, bound to the top level.
`default_nettype none

module risr_check
   import risr_pkg::*;
#(
   parameter int unsigned RADICAND_BITS = 31
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [RADICAND_BITS-1:0] req_radicand,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [ROOT_BITS-1:0]     rsp_root
);

   // a stalled response beat holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root))
      else $error("response beat changed while stalled");

   // reset empties the chain
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("chain not empty after reset");

   // back-pressure reaches the request side only from a stalled, full response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall |-> !req_stall)
      else $error("request stalled without response back-pressure");

   // a stalled request beat stays offered and unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_radicand))
      else $error("request beat changed while stalled");

endmodule : risr_check

bind rounded_integer_square_root risr_check #(
   .RADICAND_BITS (RADICAND_BITS)
) u_risr_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_radicand (req_radicand),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_root     (rsp_root)
);

`default_nettype wire

>>> tb/rounded_integer_square_root_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rounded integer square root: directed and random radicands.
module rounded_integer_square_root_tb;
   import risr_pkg::*;

   localparam int unsigned RAD_BITS       = 31;
   localparam int unsigned MAX_FLOOR_ROOT = 46340;
   localparam int unsigned N_DIRECTED     = 23;
   localparam int unsigned N_RANDOM       = 800;
   localparam int unsigned QUIET_FIRST    = 300;
   localparam int unsigned QUIET_LAST     = 420;
   localparam int unsigned HOLD_AT        = N_DIRECTED + 330;
   localparam int unsigned HOLD_CYCLES    = 60;
   localparam int unsigned DRAIN_CYCLES   = 40;
   localparam int unsigned MAX_REPORTS    = 10;

   // Expected roots in beat order, with the radicand kept for messages
   class root_book;
      logic [RAD_BITS-1:0]  pending_radicands[$];
      logic [ROOT_BITS-1:0] pending_roots[$];
      int unsigned checked  = 0;
      int unsigned failures = 0;
      int unsigned reports  = 0;
      int unsigned max_root = 0;

      // floor root by trial bits, then round up when x lies past r*r + r
      function logic [ROOT_BITS-1:0] nearest_root(logic [RAD_BITS-1:0] x);
         logic [63:0] r;
         logic [63:0] trial;
         logic [63:0] wide;
         wide = 64'(x);
         r = 64'd0;
         for (int i = ROOT_BITS - 1; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= wide) r = trial;
         end
         if (wide > r * r + r) r = r + 64'd1;
         return r[ROOT_BITS-1:0];
      endfunction

      function void note_radicand(logic [RAD_BITS-1:0] x);
         pending_radicands.push_back(x);
         pending_roots.push_back(nearest_root(x));
      endfunction

      function void check_root(logic [ROOT_BITS-1:0] got);
         logic [RAD_BITS-1:0]  x;
         logic [ROOT_BITS-1:0] want;
         if (pending_roots.size() == 0) begin
            failures++;
            if (reports < MAX_REPORTS)
               $display("ERROR: root beat %0d arrived with nothing pending", got);
            reports++;
            return;
         end
         x    = pending_radicands.pop_front();
         want = pending_roots.pop_front();
         checked++;
         if (32'(got) > max_root) max_root = 32'(got);
         if (got !== want) begin
            failures++;
            if (reports < MAX_REPORTS)
               $display("ERROR: radicand %0d: expected root %0d, got %0d", x, want, got);
            reports++;
         end
      endfunction
   endclass

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic [RAD_BITS-1:0]  req_radicand = '0;
   logic                 rsp_stall    = 1'b0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic [ROOT_BITS-1:0] rsp_root;

   bit                   quiet    = 1'b0;
   bit                   hold_rsp = 1'b0;
   int unsigned          sent     = 0;
   int unsigned          input_stall_cycles = 0;
   logic [RAD_BITS-1:0]  directed_set [0:N_DIRECTED-1];
   root_book             book;

   rounded_integer_square_root #(
      .RADICAND_BITS(RAD_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_radicand (req_radicand),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_root     (rsp_root)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // count cycles where the block pushes back on an offered beat
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) input_stall_cycles++;
   end

   // random radicand: full range, random widths, and values around rounding edges and perfect squares
   function automatic logic [RAD_BITS-1:0] random_radicand();
      logic [63:0] r;
      logic [63:0] v;
      int unsigned kind;
      int unsigned w;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         v = 64'($urandom);
      end else if (kind < 55) begin
         w = $urandom_range(1, RAD_BITS);
         v = 64'($urandom) & ((64'd1 << w) - 64'd1);
      end else if (kind < 85) begin
         r = 64'($urandom_range(1, MAX_FLOOR_ROOT));
         v = r * r + r + 64'd1 - 64'($urandom_range(0, 2));
      end else begin
         r = 64'($urandom_range(1, MAX_FLOOR_ROOT));
         v = r * r + 64'd1 - 64'($urandom_range(0, 2));
      end
      return v[RAD_BITS-1:0];
   endfunction

   // offer one radicand beat after a random gap (none while quiet), hold it until accepted
   task automatic send_radicand(input logic [RAD_BITS-1:0] x);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_radicand <= x;
      do @(posedge clock); while (req_stall !== 1'b0);
      book.note_radicand(x);
      sent++;
   endtask

   // response side: random stall per beat, plus the long hold-off
   initial begin
      int unsigned wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = quiet ? 0 : $urandom_range(0, 3);
         while (wait_cycles > 0 || hold_rsp) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
            if (wait_cycles > 0) wait_cycles--;
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         book.check_root(rsp_root);
      end
   end

   // long hold-off on the response side while the sender keeps pushing
   initial begin
      wait (sent >= HOLD_AT);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp = 1'b0;
   end

   // main stimulus
   initial begin
      int unsigned leftover;
      book = new();
      // zero, small values, rounding edges, float precision edges, full scale, bit patterns
      directed_set = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd6, 31'd7,
                       31'd65280, 31'd65281, 31'd65535, 31'd65536,
                       31'd16777215, 31'd16777216, 31'd16781312, 31'd16781313,
                       31'd2147395599, 31'd2147395600, 31'd2147441940, 31'd2147441941,
                       31'h3FFF_FFFF, 31'h4000_0000, 31'h2AAA_AAAA, 31'h5555_5555,
                       31'h7FFF_FFFF};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < N_DIRECTED; n++) send_radicand(directed_set[n]);

      // back-to-back stretch in the middle, random idling elsewhere
      for (int n = 0; n < N_RANDOM; n++) begin
         quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
         send_radicand(random_radicand());
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (book.pending_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      leftover = book.pending_roots.size();

      $display("Covered %0d radicands (%0d directed, %0d random); %0d roots checked, largest %0d.",
               sent, N_DIRECTED, N_RANDOM, book.checked, book.max_root);
      $display("Input pushed back for %0d cycles; %0d failures, %0d roots outstanding.",
               input_stall_cycles, book.failures, leftover);
      if (book.failures == 0 && leftover == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> rounded_integer_square_root.f
hdl/risr_pkg.sv
hdl/risr_cell.sv
hdl/risr_round.sv
hdl/rounded_integer_square_root.sv
hdl/risr_check.sv
tb/rounded_integer_square_root_tb.sv
